/* hw/rtl/waveform_window_peak_finder_unit_assert.svh */
// assertion macros shared by the peak finder rtl
`ifndef WAVEFORM_WINDOW_PEAK_FINDER_UNIT_ASSERT_SVH
`define WAVEFORM_WINDOW_PEAK_FINDER_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define WWPF_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define WWPF_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* hw/rtl/wwpf_pkg.sv */
// package: constants, config and status types of the peak finder
`default_nettype none
package wwpf_pkg;

  localparam int MAX_HALF_WINDOW = 8;
  localparam int SAMPLE_BITS     = 12;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HALF_WINDOW    = 8'd0,
    REG_MIN_AMPLITUDE  = 8'd1,
    REG_MIN_SEED       = 8'd2,
    REG_OFFSET_BINS    = 8'd3
  } cfg_reg_t;

  localparam logic [3:0] HALF_WINDOW_RESET = 4'd2;

  typedef struct packed {
    logic [3:0]  half_window;
    logic [11:0] min_amplitude;
    logic [11:0] min_seed_amplitude;
    logic [15:0] offset_bins;
  } cfg_t;

  // waveform state handed from the window to the evaluation stage
  typedef struct packed {
    logic        pending;
    logic [15:0] count;
    logic [11:0] crystal;
    logic [15:0] start;
  } win_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/wwpf_ifs.sv */
// channel interfaces: samples in, hits out, register writes
`default_nettype none
interface wwpf_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;
  logic        first_sample;
  logic [11:0] crystal_id;
  logic [15:0] start_bin;

  modport source (output valid, sample, first_sample, crystal_id, start_bin, input ready);
  modport sink (input valid, sample, first_sample, crystal_id, start_bin, output ready);
endinterface

interface wwpf_hit_if;
  logic        valid;
  logic        ready;
  logic [11:0] hit_crystal;
  logic [15:0] hit_bin;
  logic [11:0] hit_amplitude;
  logic        hit_is_seed;

  modport source (output valid, hit_crystal, hit_bin, hit_amplitude, hit_is_seed,
                  input ready);
  modport sink (input valid, hit_crystal, hit_bin, hit_amplitude, hit_is_seed,
                output ready);
endinterface

interface wwpf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wwpf_pkg::CFG_INDEX_BITS-1:0] index;
  logic [wwpf_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/wwpf_cfg_regs.sv */
// configuration register file
`default_nettype none
module wwpf_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  wwpf_cfg_if.sink          cfg,
  output wwpf_pkg::cfg_t    regs
);
  import wwpf_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.half_window        <= HALF_WINDOW_RESET;
      regs.min_amplitude      <= '0;
      regs.min_seed_amplitude <= '0;
      regs.offset_bins        <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HALF_WINDOW:   regs.half_window        <= cfg.data[3:0];
        REG_MIN_AMPLITUDE: regs.min_amplitude      <= cfg.data[11:0];
        REG_MIN_SEED:      regs.min_seed_amplitude <= cfg.data[11:0];
        REG_OFFSET_BINS:   regs.offset_bins        <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wwpf_window.sv */
// sample window shift line and per-waveform state
`default_nettype none
module wwpf_window #(
  parameter int MAX_HALF_WINDOW = wwpf_pkg::MAX_HALF_WINDOW,
  parameter int SAMPLE_BITS     = wwpf_pkg::SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  wwpf_sample_if.sink            smp,
  input  logic                   advance,
  output logic [SAMPLE_BITS-1:0] win [2*MAX_HALF_WINDOW+1],
  output wwpf_pkg::win_stat_t    stat
);
  import wwpf_pkg::*;

  localparam int Depth = 2 * MAX_HALF_WINDOW + 1;

  logic        pending;
  logic        pending_next;
  logic [15:0] count;
  logic [15:0] count_base;
  logic [15:0] count_next;
  logic [11:0] crystal;
  logic [15:0] start;
  logic        accept;

  // hold off new items only while a finished evaluation cannot move on
  assign smp.ready = !pending || advance;
  assign accept    = smp.valid && smp.ready;

  always_comb begin
    pending_next = accept || (pending && !advance);
    count_base   = smp.first_sample ? 16'd0 : count;
    count_next   = (count_base == 16'hFFFF) ? count_base : count_base + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
      crystal <= '0;
      start   <= '0;
    end else begin
      pending <= pending_next;
      if (accept) begin
        count <= count_next;
        if (smp.first_sample) begin
          crystal <= smp.crystal_id;
          start   <= smp.start_bin;
        end
      end
    end
  end

  // newest sample at index 0
  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= SAMPLE_BITS'(smp.sample);
      for (int i = 1; i < Depth; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  always_comb begin
    stat.pending = pending;
    stat.count   = count;
    stat.crystal = crystal;
    stat.start   = start;
  end

endmodule
`default_nettype wire

/* hw/rtl/wwpf_peak_eval.sv */
// window maximum tree, peak test, bin arithmetic and hit output register
`default_nettype none
module wwpf_peak_eval #(
  parameter int MAX_HALF_WINDOW = wwpf_pkg::MAX_HALF_WINDOW,
  parameter int SAMPLE_BITS     = wwpf_pkg::SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] win [2*MAX_HALF_WINDOW+1],
  input  wwpf_pkg::win_stat_t    stat,
  input  wwpf_pkg::cfg_t         cfg,
  output logic                   advance,
  wwpf_hit_if.source             hits
);
  import wwpf_pkg::*;

  localparam int Depth    = 2 * MAX_HALF_WINDOW + 1;
  localparam int IdxBits  = $clog2(Depth);
  localparam int HalfBits = $clog2(MAX_HALF_WINDOW + 1);
  localparam int Leaves   = 1 << IdxBits;
  localparam int CmpBits  = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam logic [7:0] MaxHalf8 = 8'(MAX_HALF_WINDOW);

  logic [7:0]             hw8;
  logic [7:0]             eff8;
  logic [7:0]             span8;
  logic [HalfBits-1:0]    eff;
  logic [SAMPLE_BITS-1:0] node [1:2*Leaves-1];
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS-1:0] centre;
  logic [SAMPLE_BITS-1:0] follow;
  logic [16:0]            bin_sum;
  logic [16:0]            bin_sub;
  logic [16:0]            bin_diff;
  logic [15:0]            bin;
  logic                   full;
  logic                   is_peak;
  logic                   hit;

  // half window clamped to 1..MAX_HALF_WINDOW
  always_comb begin
    hw8 = {4'd0, cfg.half_window};
    if (hw8 == 8'd0) begin
      eff8 = 8'd1;
    end else if (hw8 > MaxHalf8) begin
      eff8 = MaxHalf8;
    end else begin
      eff8 = hw8;
    end
    eff   = eff8[HalfBits-1:0];
    span8 = {eff8[6:0], 1'b0} + 8'd1;
  end

  // max tree, entries beyond the active span read as zero
  always_comb begin
    for (int i = 0; i < Leaves; i++) begin
      if (i < Depth && 8'(i) < span8) begin
        node[Leaves+i] = win[i];
      end else begin
        node[Leaves+i] = '0;
      end
    end
    for (int k = Leaves - 1; k >= 1; k--) begin
      node[k] = (node[2*k] > node[2*k+1]) ? node[2*k] : node[2*k+1];
    end
    peak = node[1];
  end

  always_comb begin
    centre   = win[IdxBits'(eff)];
    follow   = win[IdxBits'(eff - 1'b1)];
    full     = {8'd0, span8} <= stat.count;
    is_peak  = (CmpBits'(peak) > CmpBits'(cfg.min_amplitude)) && (centre == peak)
               && (centre != follow);
    bin_sum  = {1'b0, stat.start} + {1'b0, stat.count};
    bin_sub  = 17'(eff8) + {1'b0, cfg.offset_bins} + 17'd1;
    bin_diff = bin_sum - bin_sub;
    bin      = bin_diff[16] ? 16'hFFFF : bin_diff[15:0];
    // negative bin drops the hit
    hit      = full && is_peak && (bin_sum >= bin_sub);
  end

  assign advance = !hits.valid || hits.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits.valid <= 1'b0;
    end else if (advance) begin
      hits.valid <= stat.pending && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.pending && hit) begin
      hits.hit_crystal   <= stat.crystal;
      hits.hit_bin       <= bin;
      hits.hit_amplitude <= 12'(peak);
      hits.hit_is_seed   <= CmpBits'(peak) > CmpBits'(cfg.min_seed_amplitude);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/waveform_window_peak_finder_unit.sv */
// Sliding window peak finder over digitized waveforms.
// samples: one ADC sample per item with first_sample, crystal_id and start_bin;
//   first_sample opens a new waveform and latches crystal and start bin.
// hits: zero or one item per sample, raised when the window is full, its centre is the
//   maximum, above min_amplitude, differs from the following sample and the bin is >= 0.
// cfg: register writes (index 0..3), always ready; write only while idle.
// Order: the accepting edge shifts the sample into the window; hits.valid is registered
//   and loads from the evaluated window once the hit output can advance.
// Throughput: one sample per cycle while no hit is stalled, set by the combinational
//   comparator tree over the 2*MAX_HALF_WINDOW+1 window taps feeding the hit register.
// Stall: while a hit waits on hits.ready the finished evaluation holds and
//   samples.ready drops; one evaluated sample and one hit are held at most.
// Reset: synchronous rst clears the waveform state and sample count, loads
//   half_window 2 and zero thresholds and offset; no hit is pending.
`default_nettype none
`include "waveform_window_peak_finder_unit_assert.svh"
module waveform_window_peak_finder_unit #(
  parameter int MAX_HALF_WINDOW = wwpf_pkg::MAX_HALF_WINDOW,
  parameter int SAMPLE_BITS     = wwpf_pkg::SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  wwpf_cfg_if.sink    cfg,
  wwpf_sample_if.sink samples,
  wwpf_hit_if.source  hits
);
  import wwpf_pkg::*;

  cfg_t                   regs;
  win_stat_t              stat;
  logic                   advance;
  logic [SAMPLE_BITS-1:0] win [2*MAX_HALF_WINDOW+1];

  wwpf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  wwpf_window #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .smp     (samples),
    .advance (advance),
    .win     (win),
    .stat    (stat)
  );

  wwpf_peak_eval #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_eval (
    .clk     (clk),
    .rst     (rst),
    .win     (win),
    .stat    (stat),
    .cfg     (regs),
    .advance (advance),
    .hits    (hits)
  );

  `WWPF_ASSERT_NEXT(a_accept_pending, samples.valid && samples.ready, stat.pending,
    "accepted item not under evaluation")
  `WWPF_ASSERT_NEXT(a_held_eval, stat.pending && !advance,
    stat.pending && $stable(stat.count), "stalled evaluation lost its state")
  `WWPF_ASSERT_NOW(a_ready_cause, !samples.ready,
    stat.pending && hits.valid && !hits.ready, "input stalled without a blocked hit")
  `WWPF_ASSERT_NEXT(a_first_latch, samples.valid && samples.ready && samples.first_sample,
    stat.count == 16'd1 && stat.crystal == $past(samples.crystal_id),
    "new waveform not opened")

endmodule
`default_nettype wire

/* test/wwpf_hit_checker.sv */
`timescale 1ns / 100ps
// checker for the peak finder: predicts hits from accepted samples and compares them
module wwpf_hit_checker
  import wwpf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  wwpf_cfg_if    cfg,
  wwpf_sample_if samples,
  wwpf_hit_if    hits,
  output int     failures,
  output int     outstanding,
  output int     hits_checked
);

  localparam int DEPTH     = 2 * MAX_HALF_WINDOW + 1;
  localparam int HIT_SLOTS = 16;

  typedef struct packed {
    logic [11:0] crystal;
    logic [15:0] bin;
    logic [11:0] amplitude;
    logic        seed;
  } peak_hit_t;

  // ring of predicted hits, oldest at slot_head
  peak_hit_t hit_slots [0:HIT_SLOTS-1];
  int        slot_head;
  int        slot_tail;
  int        slot_fill;

  logic [11:0] window [0:DEPTH-1];
  logic [15:0] wave_count;
  logic [11:0] wave_crystal;
  logic [15:0] wave_start;

  logic [3:0]  half_window;
  logic [11:0] min_amplitude;
  logic [11:0] min_seed;
  logic [15:0] offset_bins;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (failures < 100) begin
      $display("%0t: mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
    failures++;
  endtask

  task automatic clear_state();
    int i;
    for (i = 0; i < DEPTH; i++) window[i] = '0;
    wave_count    = '0;
    wave_crystal  = '0;
    wave_start    = '0;
    half_window   = HALF_WINDOW_RESET;
    min_amplitude = '0;
    min_seed      = '0;
    offset_bins   = '0;
    slot_head     = 0;
    slot_tail     = 0;
    slot_fill     = 0;
  endtask

  // shift the sample in and work out whether the window centre is a reportable peak
  task automatic predict_peak(input logic [11:0] smp, input logic first,
                              input logic [11:0] cid, input logic [15:0] sb);
    int i;
    int h;
    int span;
    int bin;
    logic [11:0] peak;
    logic [11:0] centre;
    logic [11:0] follow;
    peak_hit_t hit;
    h = (half_window == 4'd0) ? 1 :
        (int'(half_window) > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(half_window);
    span = 2 * h + 1;
    if (first) begin
      wave_count   = '0;
      wave_crystal = cid;
      wave_start   = sb;
    end
    for (i = DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = smp;
    if (wave_count != 16'hFFFF) wave_count++;
    if (int'(wave_count) < span) return;
    peak = '0;
    for (i = 0; i < span; i++) begin
      if (window[i] > peak) peak = window[i];
    end
    centre = window[h];
    follow = window[h - 1];
    if (!(peak > min_amplitude && centre == peak && centre != follow)) return;
    bin = int'(wave_start) + int'(wave_count) - 1 - h - int'(offset_bins);
    if (bin < 0) return;
    if (bin > 65535) bin = 65535;
    hit.crystal   = wave_crystal;
    hit.bin       = bin[15:0];
    hit.amplitude = peak;
    hit.seed      = (peak > min_seed);
    if (slot_fill == HIT_SLOTS) begin
      report_mismatch("predicted hits beyond ring depth", slot_fill, HIT_SLOTS - 1);
      return;
    end
    hit_slots[slot_tail] = hit;
    slot_tail = (slot_tail + 1) % HIT_SLOTS;
    slot_fill++;
  endtask

  task automatic check_hit();
    peak_hit_t want;
    if (slot_fill == 0) begin
      report_mismatch("hit with nothing pending, bin", hits.hit_bin, 0);
      return;
    end
    want = hit_slots[slot_head];
    slot_head = (slot_head + 1) % HIT_SLOTS;
    slot_fill--;
    hits_checked++;
    if (hits.hit_crystal !== want.crystal)
      report_mismatch("hit_crystal", hits.hit_crystal, want.crystal);
    if (hits.hit_bin !== want.bin)
      report_mismatch("hit_bin", hits.hit_bin, want.bin);
    if (hits.hit_amplitude !== want.amplitude)
      report_mismatch("hit_amplitude", hits.hit_amplitude, want.amplitude);
    if (hits.hit_is_seed !== want.seed)
      report_mismatch("hit_is_seed", hits.hit_is_seed, want.seed);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      // compare first so a hit can never match an item taken at the same edge
      if (hits.valid && hits.ready) check_hit();
      if (samples.valid && samples.ready) begin
        predict_peak(samples.sample, samples.first_sample, samples.crystal_id,
                     samples.start_bin);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HALF_WINDOW:   half_window   = cfg.data[3:0];
          REG_MIN_AMPLITUDE: min_amplitude = cfg.data[11:0];
          REG_MIN_SEED:      min_seed      = cfg.data[11:0];
          REG_OFFSET_BINS:   offset_bins   = cfg.data;
          default: ;
        endcase
      end
    end
    outstanding = slot_fill;
  end

endmodule

/* test/waveform_window_peak_finder_unit_tb.sv */
`timescale 1ns / 100ps
// testbench top for the peak finder: clock, reset, stimulus and verdict
module waveform_window_peak_finder_unit_tb;
  import wwpf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [7:0] REG_UNUSED = 8'd4;

  logic clk;
  logic rst;

  wwpf_cfg_if    cfg_ch ();
  wwpf_sample_if sample_ch ();
  wwpf_hit_if    hit_ch ();

  int  failures;
  int  outstanding;
  int  hits_checked;
  int  cycle_count;
  int  items_sent;
  int  settings_count;
  int  burst_left;
  int  half_eff;
  bit  gaps_on;
  bit  hold_request;

  waveform_window_peak_finder_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .hits    (hit_ch)
  );

  wwpf_hit_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_ch),
    .samples      (sample_ch),
    .hits         (hit_ch),
    .failures     (failures),
    .outstanding  (outstanding),
    .hits_checked (hits_checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hits still pending", cycle_count, outstanding);
      $display("FAIL waveform_window_peak_finder_unit");
      $finish;
    end
  end

  // hit receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int tick;
    int mode;
    tick = 0;
    mode = 0;
    hit_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hit_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (tick % 97 == 0) mode = $urandom_range(0, 3);
        tick++;
        case (mode)
          0: hit_ch.ready <= 1'b1;
          1: hit_ch.ready <= 1'($urandom_range(0, 1));
          2: hit_ch.ready <= ($urandom_range(0, 3) == 0);
          default: hit_ch.ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  task automatic take_gap();
    if (!gaps_on) return;
    if (burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_sample(input logic [11:0] smp, input logic first,
                             input logic [11:0] cid, input logic [15:0] sb);
    sample_ch.valid        <= 1'b1;
    sample_ch.sample       <= smp;
    sample_ch.first_sample <= first;
    sample_ch.crystal_id   <= cid;
    sample_ch.start_bin    <= sb;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    take_gap();
  endtask

  // drop valid and wait until every predicted hit is out and the pipe has drained
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] h, input logic [11:0] min_amp,
                            input logic [11:0] seed, input logic [15:0] off);
    settle();
    write_reg(REG_HALF_WINDOW, {12'($urandom), h});
    write_reg(REG_MIN_AMPLITUDE, {4'($urandom), min_amp});
    write_reg(REG_MIN_SEED, {4'($urandom), seed});
    write_reg(REG_OFFSET_BINS, off);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_ch.valid <= 1'b0;
    half_eff = (h == 4'd0) ? 1 : (int'(h) > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(h);
    settings_count++;
  endtask

  // one waveform: noise, a triangular pulse, a flat run with ties, or a noisy pulse
  task automatic send_waveform();
    int len;
    int shape;
    int peak_at;
    int amp;
    int slope;
    int from_peak;
    int val;
    int i;
    logic [11:0] cid;
    logic [15:0] sb;
    logic fresh;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2 * half_eff)
                                      : $urandom_range(2 * half_eff + 1, 2 * half_eff + 24);
    shape   = $urandom_range(0, 3);
    cid     = 12'($urandom);
    sb      = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65300, 65535)) : 16'($urandom);
    fresh   = ($urandom_range(0, 9) != 0);
    peak_at = $urandom_range(0, len - 1);
    amp     = $urandom_range(0, 4095);
    slope   = $urandom_range(1, 600);
    for (i = 0; i < len; i++) begin
      from_peak = (i > peak_at) ? i - peak_at : peak_at - i;
      case (shape)
        0: val = $urandom_range(0, 4095);
        1: val = (from_peak * slope > amp) ? 0 : amp - from_peak * slope;
        2: val = $urandom_range(0, 3);
        default: val = (from_peak * slope > amp) ? $urandom_range(0, 15)
                                                 : amp - from_peak * slope
                                                   - $urandom_range(0, 1);
      endcase
      if (val < 0) val = 0;
      send_sample(12'(val), fresh && (i == 0), (i == 0) ? cid : 12'($urandom),
                  (i == 0) ? sb : 16'($urandom));
    end
  endtask

  initial begin
    int p;
    int k;
    int phase_items;
    logic [11:0] val;
    rst = 1'b1;
    hold_request = 1'b0;
    gaps_on = 1'b0;
    burst_left = 0;
    half_eff = int'(HALF_WINDOW_RESET);
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample       = '0;
    sample_ch.first_sample = 1'b0;
    sample_ch.crystal_id   = '0;
    sample_ch.start_bin    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, no waveform opened yet: crystal and start taken as zero
    gaps_on = 1'b1;
    send_sample(12'd0, 1'b0, 12'd77, 16'd500);
    send_sample(12'd0, 1'b0, 12'd77, 16'd500);
    send_sample(12'd4095, 1'b0, 12'd77, 16'd500);
    send_sample(12'd0, 1'b0, 12'd77, 16'd500);
    send_sample(12'd0, 1'b0, 12'd77, 16'd500);
    // equal neighbors: only the later of two equal samples can be a peak
    send_sample(12'd7, 1'b0, 12'd1, 16'd1);
    send_sample(12'd7, 1'b0, 12'd1, 16'd1);
    send_sample(12'd0, 1'b0, 12'd1, 16'd1);
    send_sample(12'd0, 1'b0, 12'd1, 16'd1);

    // half window zero acts as one; bin saturates at the top
    set_config(4'd0, 12'd100, 12'd200, 16'd0);
    send_sample(12'd0, 1'b1, 12'd4095, 16'd65535);
    send_sample(12'd150, 1'b0, 12'd0, 16'd0);
    send_sample(12'd0, 1'b0, 12'd0, 16'd0);
    send_sample(12'd250, 1'b0, 12'd0, 16'd0);
    send_sample(12'd250, 1'b0, 12'd0, 16'd0);
    send_sample(12'd0, 1'b0, 12'd0, 16'd0);
    send_sample(12'd100, 1'b0, 12'd0, 16'd0);
    send_sample(12'd0, 1'b0, 12'd0, 16'd0);

    // full offset: a hit with a negative bin is dropped
    set_config(4'd1, 12'd0, 12'd4095, 16'd65535);
    send_sample(12'd0, 1'b1, 12'd1, 16'd0);
    send_sample(12'd4095, 1'b0, 12'd0, 16'd0);
    send_sample(12'd0, 1'b0, 12'd0, 16'd0);
    send_sample(12'd0, 1'b1, 12'd2, 16'd65535);
    send_sample(12'd4095, 1'b0, 12'd0, 16'd0);
    send_sample(12'd0, 1'b0, 12'd0, 16'd0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_config(4'd1, 12'd0, 12'd0, 16'd0);
        1: set_config(4'd8, 12'($urandom_range(0, 1500)), 12'($urandom),
                      16'($urandom_range(0, 300)));
        2: set_config(4'd0, 12'd0, 12'd4095, 16'd65535);
        3: set_config(4'd15, 12'($urandom_range(0, 1500)), 12'd0,
                      16'($urandom_range(0, 300)));
        4: set_config(4'($urandom_range(1, 8)), 12'd4095, 12'($urandom),
                      16'($urandom_range(0, 300)));
        default: set_config(4'($urandom), 12'($urandom_range(0, 2500)), 12'($urandom),
                            16'($urandom_range(0, 400)));
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_items = items_sent;
      while (items_sent - phase_items < 35) send_waveform();
    end

    // receiver holds off while samples keep coming, so the block must stall its input
    set_config(4'd1, 12'd0, 12'd2048, 16'd0);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) begin
      val = (k % 2 == 1) ? 12'($urandom_range(1, 4095)) : 12'd0;
      send_sample(val, k == 0, 12'($urandom), 16'($urandom));
    end

    settle();
    repeat (10) @(negedge clk);
    $display("%0d samples over %0d register settings, %0d hits compared", items_sent,
             settings_count, hits_checked);
    $display("covered stalled input under a held-off receiver, clamped windows and bin limits");
    if (failures == 0) begin
      $display("PASS waveform_window_peak_finder_unit");
    end else begin
      $display("FAIL waveform_window_peak_finder_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/wwpf_pkg.sv
hw/rtl/wwpf_ifs.sv
hw/rtl/wwpf_cfg_regs.sv
hw/rtl/wwpf_window.sv
hw/rtl/wwpf_peak_eval.sv
hw/rtl/waveform_window_peak_finder_unit.sv
test/wwpf_hit_checker.sv
test/waveform_window_peak_finder_unit_tb.sv
